FILE: design/ads_pkg.sv
package ads_pkg;

  localparam int MAX_BLOCKS_DEF = 64;

  localparam int AW     = 7;
  localparam int T_BASE = 18;
  localparam int Y_BASE = 27;
  localparam int S_BASE = 45;
  localparam int P_BASE = 71;
  localparam int TMP    = 79;
  localparam int C_BASE = 110;
  localparam int NOPS   = 159;
  localparam int PCW    = 8;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;
  localparam logic [1:0] OP_MUL  = 2'd3;

  typedef struct packed {
    logic [1:0]    opc;
    logic [AW-1:0] dst;
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    logic [3:0]    k;
  } op_t;

  typedef op_t [NOPS-1:0] prog_t;
  typedef logic [15:0][15:0] ktab_t;

  typedef struct packed {
    logic       start;
    logic       two_ch;
    logic       clr;
    logic [4:0] rd_idx;
  } eng_ctl_t;

  typedef struct packed {
    logic        we;
    logic [5:0]  addr;
    logic [15:0] data;
  } fb_wr_t;

  function automatic op_t mk(logic [1:0] opc, int d, int a, int b, int k);
    op_t o;
    o.opc = opc;
    o.dst = AW'(d);
    o.a   = AW'(a);
    o.b   = AW'(b);
    o.k   = 4'(k);
    return o;
  endfunction

  // Q28 constants rounded to the 16-bit multiplier operand
  function automatic ktab_t build_ktab();
    ktab_t t;
    longint c;
    for (int i = 0; i < 16; i++) begin
      case (i)
        0:  c = 64'h1fe0d3b4;
        1:  c = 64'h1ee8dd47;
        2:  c = 64'h1d007930;
        3:  c = 64'h1a367e59;
        4:  c = 64'h16a09e66;
        5:  c = 64'h125abcf8;
        6:  c = 64'h0d8616bc;
        7:  c = 64'h08483ee1;
        8:  c = 64'h02c9fad7;
        9:  c = -64'sh1f838b8d;
        10: c = -64'sh1bb67ae8;
        11: c = -64'sh18836fa3;
        12: c = -64'sh1491b752;
        13: c = -64'sh0af1d43a;
        14: c = -64'sh058e86a0;
        default: c = 64'h1e11f642;
      endcase
      t[i] = 16'((c + 64'sd32768) >>> 16);
    end
    return t;
  endfunction

  localparam ktab_t KTAB = build_ktab();

  function automatic prog_t build_prog();
    prog_t p;
    int n;
    int tb;
    int yb;
    int s;
    int q;
    p = '0;
    n = 0;
    for (int i = 0; i < 18; i++) begin
      p[n] = mk(OP_LOAD, i, i, 0, 0); n++;
    end
    for (int h = 0; h < 2; h++) begin
      tb = T_BASE;
      yb = Y_BASE + h;
      s  = S_BASE;
      q  = P_BASE;
      for (int i = 0; i < 9; i++) begin
        if (h == 0) begin
          p[n] = mk(OP_ADD, tb + i, i, 17 - i, 0); n++;
        end else begin
          p[n] = mk(OP_SUB, tb + i, i, 17 - i, 0); n++;
          p[n] = mk(OP_MUL, tb + i, tb + i, 0, i); n++;
        end
      end
      p[n] = mk(OP_ADD, s + 0, tb + 3, tb + 5, 0); n++;
      p[n] = mk(OP_SUB, s + 1, tb + 3, tb + 5, 0); n++;
      p[n] = mk(OP_ADD, s + 2, tb + 6, tb + 2, 0); n++;
      p[n] = mk(OP_SUB, s + 3, tb + 6, tb + 2, 0); n++;
      p[n] = mk(OP_ADD, s + 4, tb + 1, tb + 7, 0); n++;
      p[n] = mk(OP_SUB, s + 5, tb + 1, tb + 7, 0); n++;
      p[n] = mk(OP_ADD, s + 6, tb + 8, tb + 0, 0); n++;
      p[n] = mk(OP_SUB, s + 7, tb + 8, tb + 0, 0); n++;
      p[n] = mk(OP_ADD, s + 8, s + 0, s + 2, 0); n++;
      p[n] = mk(OP_SUB, s + 9, s + 0, s + 2, 0); n++;
      p[n] = mk(OP_SUB, s + 10, s + 0, s + 6, 0); n++;
      p[n] = mk(OP_SUB, s + 11, s + 2, s + 6, 0); n++;
      p[n] = mk(OP_ADD, s + 12, s + 8, s + 6, 0); n++;
      p[n] = mk(OP_SUB, s + 13, s + 1, s + 3, 0); n++;
      p[n] = mk(OP_ADD, s + 14, s + 13, s + 7, 0); n++;
      p[n] = mk(OP_ADD, s + 15, s + 3, s + 7, 0); n++;
      p[n] = mk(OP_SUB, s + 16, s + 1, s + 7, 0); n++;
      p[n] = mk(OP_ADD, s + 17, s + 1, s + 3, 0); n++;
      p[n] = mk(OP_MUL, q + 0, s + 17, 0, 12); n++;
      p[n] = mk(OP_MUL, q + 1, s + 16, 0, 9); n++;
      p[n] = mk(OP_MUL, q + 2, s + 15, 0, 13); n++;
      // this product is output 6 itself
      p[n] = mk(OP_MUL, yb + 6, s + 14, 0, 10); n++;
      p[n] = mk(OP_MUL, q + 4, s + 5, 0, 10); n++;
      p[n] = mk(OP_MUL, q + 5, s + 11, 0, 15); n++;
      p[n] = mk(OP_MUL, q + 6, s + 10, 0, 14); n++;
      p[n] = mk(OP_MUL, q + 7, s + 9, 0, 11); n++;
      p[n] = mk(OP_ADD, s + 18, tb + 4, s + 4, 0); n++;
      p[n] = mk(OP_ADD, TMP, tb + 4, tb + 4, 0); n++;
      p[n] = mk(OP_SUB, s + 19, TMP, s + 4, 0); n++;
      p[n] = mk(OP_ADD, s + 20, s + 19, q + 5, 0); n++;
      p[n] = mk(OP_SUB, s + 21, s + 19, q + 5, 0); n++;
      p[n] = mk(OP_ADD, s + 22, s + 19, q + 6, 0); n++;
      p[n] = mk(OP_ADD, s + 23, q + 4, q + 2, 0); n++;
      p[n] = mk(OP_SUB, s + 24, q + 4, q + 2, 0); n++;
      p[n] = mk(OP_ADD, s + 25, q + 4, q + 1, 0); n++;
      p[n] = mk(OP_ADD, yb + 0, s + 18, s + 12, 0); n++;
      p[n] = mk(OP_SUB, yb + 2, q + 0, s + 25, 0); n++;
      p[n] = mk(OP_SUB, yb + 4, q + 7, s + 20, 0); n++;
      p[n] = mk(OP_SUB, yb + 8, s + 21, q + 6, 0); n++;
      p[n] = mk(OP_SUB, yb + 10, s + 24, q + 1, 0); n++;
      p[n] = mk(OP_ADD, TMP, s + 18, s + 18, 0); n++;
      p[n] = mk(OP_SUB, yb + 12, s + 12, TMP, 0); n++;
      p[n] = mk(OP_ADD, yb + 14, s + 23, q + 0, 0); n++;
      p[n] = mk(OP_ADD, yb + 16, s + 22, q + 7, 0); n++;
    end
    for (int i = 3; i < 18; i += 2) begin
      p[n] = mk(OP_SUB, Y_BASE + i, Y_BASE + i, Y_BASE + i - 2, 0); n++;
    end
    for (int i = 0; i < 18; i++) begin
      p[n] = mk(OP_ADD, C_BASE + i, C_BASE + i, Y_BASE + i, 0); n++;
    end
    return p;
  endfunction

  localparam prog_t PROG = build_prog();

endpackage

FILE: design/ads_div.sv
module ads_div #(
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [31:0]   quo
);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [31:0]   mag_r, mag_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic          neg_r, neg_nxt;
  logic [31:0]   quo_r, quo_nxt;
  logic [DW:0]   trial;
  logic          qbit;

  assign trial = {rem_r, mag_r[31]};
  assign qbit  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      mag_nxt  = num[31] ? (~num + 32'd1) : num;
      rem_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = num[31];
    end else if (busy_r) begin
      rem_nxt = qbit ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      mag_nxt = {mag_r[30:0], qbit};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        quo_nxt  = neg_r ? (~mag_nxt + 32'd1) : mag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: design/ads_engine.sv
module ads_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  ads_pkg::eng_ctl_t  ctl,
  input  ads_pkg::fb_wr_t    fb_wr,
  output logic               busy,
  output logic [31:0]        rd_data
);

  localparam logic [ads_pkg::AW-1:0]  CB   = ads_pkg::AW'(ads_pkg::C_BASE);
  localparam logic [ads_pkg::PCW-1:0] LAST = ads_pkg::PCW'(ads_pkg::NOPS - 1);

  logic [15:0] fb_mem [36];
  logic [31:0] rf [2**ads_pkg::AW];
  logic [17:0] cvalid_r;

  logic                   busy_r, busy_nxt;
  logic                   phase_r, phase_nxt;
  logic                   chan_r, chan_nxt;
  logic                   two_r, two_nxt;
  logic [ads_pkg::PCW-1:0] pc_r, pc_nxt;

  ads_pkg::op_t op;
  logic [ads_pkg::AW-1:0] ra;
  logic [5:0]  fb_ra;
  logic [15:0] fb_q_r;
  logic [31:0] rda_r, rdb_r;
  logic        va_r;
  logic [31:0] xa;
  logic signed [19:0] ma;
  logic signed [15:0] kb;
  logic signed [35:0] prod;
  logic [31:0] wd;
  logic        we;

  assign op    = ads_pkg::PROG[pc_r];
  assign ra    = busy_r ? op.a : CB + ads_pkg::AW'(ctl.rd_idx);
  assign fb_ra = two_r ? {op.a[4:0], chan_r} : {1'b0, op.a[4:0]};

  always_ff @(posedge clk) begin
    if (fb_wr.we) begin
      fb_mem[fb_wr.addr] <= fb_wr.data;
    end
    fb_q_r <= fb_mem[fb_ra];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      rf[op.dst] <= wd;
    end
    rda_r <= rf[ra];
    rdb_r <= rf[op.b];
    va_r  <= (ra < CB) || cvalid_r[5'(ra - CB)];
  end

  assign xa   = (va_r ? rda_r : 32'd0) + 32'd2048;
  assign ma   = $signed(xa[31:12]);
  assign kb   = $signed(ads_pkg::KTAB[op.k]);
  assign prod = ma * kb;

  always_comb begin
    case (op.opc)
      ads_pkg::OP_LOAD: wd = {{16{fb_q_r[15]}}, fb_q_r};
      ads_pkg::OP_ADD:  wd = (va_r ? rda_r : 32'd0) + rdb_r;
      ads_pkg::OP_SUB:  wd = (va_r ? rda_r : 32'd0) - rdb_r;
      ads_pkg::OP_MUL:  wd = prod[31:0];
      default:          wd = '0;
    endcase
  end

  assign we = busy_r && phase_r;

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    chan_nxt  = chan_r;
    two_nxt   = two_r;
    pc_nxt    = pc_r;
    if (ctl.start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      chan_nxt  = 1'b0;
      two_nxt   = ctl.two_ch;
      pc_nxt    = '0;
    end else if (busy_r) begin
      phase_nxt = ~phase_r;
      if (phase_r) begin
        // advance; rerun the program for the second channel
        if (pc_r == LAST) begin
          pc_nxt = '0;
          if (two_r && !chan_r) begin
            chan_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b0;
          end
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      phase_r  <= 1'b0;
      chan_r   <= 1'b0;
      two_r    <= 1'b0;
      pc_r     <= '0;
      cvalid_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      chan_r  <= chan_nxt;
      two_r   <= two_nxt;
      pc_r    <= pc_nxt;
      if (ctl.clr) begin
        cvalid_r <= '0;
      end else if (we && op.dst >= CB) begin
        cvalid_r[5'(op.dst - CB)] <= 1'b1;
      end
    end
  end

  assign busy    = busy_r;
  assign rd_data = va_r ? rda_r : 32'd0;

endmodule

FILE: design/averaged_dct18_spectrum.sv
// channel | direction | signals                                    | request when
// in      | slave     | in_tvalid in_tready in_tdata in_tlast      | tvalid && tready
// out     | master    | out_tvalid out_tready out_tdata out_tuser  | tvalid && tready
//         |           | out_tlast                                  |
// cfg     | slave     | cfg_valid cfg_ready cfg_data               | valid && ready
// Closing a frame runs the 159-step transform program on the work register file
// once per channel, unless the block count would pass MAX_BLOCKS; each step reads
// its operands, then executes and writes back. Each of the 18 results on a last
// sample goes through the one-bit-per-cycle divider unless no block was counted.
// Synchronous active-low reset clears counts and the coefficient valid bits.
// in_tready is low while a frame or the results are busy.
module averaged_dct18_spectrum #(
  parameter int MAX_BLOCKS = ads_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] coef_index, [36:5] average, [39:37] zero
  output logic        out_tuser,  // [0] empty_res
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int BCW = $clog2(MAX_BLOCKS + 3);
  localparam logic [BCW-1:0] MAXB = BCW'(MAX_BLOCKS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RUN   = 3'd1;
  localparam logic [2:0] S_OREQ  = 3'd2;
  localparam logic [2:0] S_OLOAD = 3'd3;
  localparam logic [2:0] S_ODIV  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]     st_r, st_nxt;
  logic           stereo_r;
  logic [5:0]     cnt_r, cnt_nxt;
  logic [BCW-1:0] bc_r, bc_nxt;
  logic           last_r, last_nxt;
  logic [4:0]     k_r, k_nxt;
  logic [31:0]    avg_r, avg_nxt;
  logic           empty_r, empty_nxt;

  ads_pkg::eng_ctl_t ctl;
  ads_pkg::fb_wr_t   fb_wr;
  logic           eng_busy;
  logic [31:0]    rd_data;
  logic           div_start;
  logic           div_done;
  logic [31:0]    div_quo;

  logic           acc;
  logic [5:0]     cnt_inc;
  logic [5:0]     flen;
  logic [BCW-1:0] bc_sum;

  assign cfg_ready = 1'b1;
  assign in_tready = st_r == S_IDLE;
  assign acc       = in_tvalid && in_tready;
  assign cnt_inc   = cnt_r + 6'd1;
  assign flen      = stereo_r ? 6'd36 : 6'd18;
  assign bc_sum    = bc_r + (stereo_r ? BCW'(2) : BCW'(1));

  assign fb_wr.we   = acc;
  assign fb_wr.addr = cnt_r;
  assign fb_wr.data = in_tdata;

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    bc_nxt     = bc_r;
    last_nxt   = last_r;
    k_nxt      = k_r;
    avg_nxt    = avg_r;
    empty_nxt  = empty_r;
    ctl.start  = 1'b0;
    ctl.two_ch = stereo_r;
    ctl.clr    = 1'b0;
    ctl.rd_idx = k_r;
    div_start  = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (acc) begin
          last_nxt = in_tlast;
          cnt_nxt  = cnt_inc;
          if (in_tlast) begin
            st_nxt = S_OREQ;
          end
          if (cnt_inc >= flen) begin
            cnt_nxt = '0;
            bc_nxt  = (bc_sum > MAXB) ? MAXB : bc_sum;
            if (bc_sum <= MAXB) begin
              ctl.start = 1'b1;
              st_nxt    = S_RUN;
            end
          end
          if (in_tlast) begin
            cnt_nxt = '0;
          end
        end
      end
      S_RUN: begin
        if (!eng_busy) begin
          st_nxt = last_r ? S_OREQ : S_IDLE;
        end
      end
      S_OREQ: begin
        st_nxt = S_OLOAD;
      end
      S_OLOAD: begin
        if (bc_r == '0) begin
          avg_nxt   = '0;
          empty_nxt = 1'b1;
          st_nxt    = S_OUT;
        end else begin
          empty_nxt = 1'b0;
          div_start = 1'b1;
          st_nxt    = S_ODIV;
        end
      end
      S_ODIV: begin
        if (div_done) begin
          avg_nxt = div_quo;
          st_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          if (k_r == 5'd17) begin
            // drop the run: clear sums and counts
            k_nxt   = '0;
            bc_nxt  = '0;
            ctl.clr = 1'b1;
            st_nxt  = S_IDLE;
          end else begin
            k_nxt  = k_r + 5'd1;
            st_nxt = S_OREQ;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      stereo_r <= 1'b0;
      cnt_r    <= '0;
      bc_r     <= '0;
      last_r   <= 1'b0;
      k_r      <= '0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      bc_r   <= bc_nxt;
      last_r <= last_nxt;
      k_r    <= k_nxt;
      if (cfg_valid) begin
        stereo_r <= cfg_data;
      end
    end
    avg_r   <= avg_nxt;
    empty_r <= empty_nxt;
  end

  ads_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .fb_wr   (fb_wr),
    .busy    (eng_busy),
    .rd_data (rd_data)
  );

  ads_div #(
    .DW (BCW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (rd_data),
    .den   (bc_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_tvalid = st_r == S_OUT;
  assign out_tdata  = {3'b000, avg_r, k_r};
  assign out_tuser  = empty_r;
  assign out_tlast  = k_r == 5'd17;

endmodule

FILE: sim/testbench.sv
module testbench;

  localparam int NBLK = 64;
  localparam int SETTLE = 800;

  typedef bit [31:0] word9_t [9];

  typedef struct {
    bit [4:0]  idx;
    bit [31:0] avg;
    bit        empty;
    bit        fin;
  } coef_res_t;

  typedef struct {
    bit [15:0] sample;
    bit        last;
    bit        typed_empty;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  coef_res_t coef_q[$];
  int        errors = 0;
  int        tx_idle = 21;
  int        rx_idle = 48;

  // predictor state
  bit        pm_stereo;
  bit [15:0] pm_frame[36];
  int        pm_count;
  bit [31:0] pm_sum[18];
  int        pm_blocks;

  averaged_dct18_spectrum dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Q28 constant reduced to the 16-bit multiplier operand
  function automatic int q16(longint c);
    return int'((c + 64'sd32768) >>> 16);
  endfunction

  function automatic bit [31:0] rmul(bit [31:0] x, int k);
    int a;
    bit [31:0] r;
    a = int'(x + 32'd2048) >>> 12;
    r = a * k;
    return r;
  endfunction

  function automatic word9_t dct9(word9_t x);
    word9_t y;
    bit [31:0] s0, s1, s2, s3, s4, s5, s6, s7, s8, s9, s10, s11, s12, s13;
    bit [31:0] s14, s15, s16, s17, s18, s19, s20, s21, s22, s23, s24, s25;
    bit [31:0] p0, p1, p2, p3, p4, p5, p6, p7;
    s0 = x[3] + x[5]; s1 = x[3] - x[5];
    s2 = x[6] + x[2]; s3 = x[6] - x[2];
    s4 = x[1] + x[7]; s5 = x[1] - x[7];
    s6 = x[8] + x[0]; s7 = x[8] - x[0];
    s8 = s0 + s2; s9 = s0 - s2; s10 = s0 - s6; s11 = s2 - s6;
    s12 = s8 + s6; s13 = s1 - s3; s14 = s13 + s7; s15 = s3 + s7;
    s16 = s1 - s7; s17 = s1 + s3;
    p0 = rmul(s17, q16(-64'sh1491b752));
    p1 = rmul(s16, q16(-64'sh1f838b8d));
    p2 = rmul(s15, q16(-64'sh0af1d43a));
    p3 = rmul(s14, q16(-64'sh1bb67ae8));
    p4 = rmul(s5,  q16(-64'sh1bb67ae8));
    p5 = rmul(s11, q16(64'sh1e11f642));
    p6 = rmul(s10, q16(-64'sh058e86a0));
    p7 = rmul(s9,  q16(-64'sh18836fa3));
    s18 = x[4] + s4;
    s19 = 2 * x[4] - s4;
    s20 = s19 + p5; s21 = s19 - p5; s22 = s19 + p6;
    s23 = p4 + p2; s24 = p4 - p2; s25 = p4 + p1;
    y[0] = s18 + s12;
    y[1] = p0 - s25;
    y[2] = p7 - s20;
    y[3] = p3;
    y[4] = s21 - p6;
    y[5] = s24 - p1;
    y[6] = s12 - 2 * s18;
    y[7] = s23 + p0;
    y[8] = s22 + p7;
    return y;
  endfunction

  function automatic void accumulate_dct18(bit [31:0] x[18]);
    longint sc[9];
    word9_t t, ev, od;
    bit [31:0] c[18];
    sc = '{64'h1fe0d3b4, 64'h1ee8dd47, 64'h1d007930, 64'h1a367e59, 64'h16a09e66,
           64'h125abcf8, 64'h0d8616bc, 64'h08483ee1, 64'h02c9fad7};
    for (int i = 0; i < 9; i++) t[i] = x[i] + x[17-i];
    ev = dct9(t);
    for (int i = 0; i < 9; i++) t[i] = rmul(x[i] - x[17-i], q16(sc[i]));
    od = dct9(t);
    for (int i = 0; i < 9; i++) begin
      c[2*i]   = ev[i];
      c[2*i+1] = od[i];
    end
    for (int i = 3; i < 18; i += 2) c[i] = c[i] - c[i-2];
    for (int i = 0; i < 18; i++) pm_sum[i] = pm_sum[i] + c[i];
  endfunction

  function automatic void close_frame();
    int ch;
    bit [31:0] x[18];
    ch = pm_stereo ? 2 : 1;
    if (pm_blocks + ch <= NBLK) begin
      for (int c = 0; c < ch; c++) begin
        for (int i = 0; i < 18; i++)
          x[i] = {{16{pm_frame[(i*ch+c)%36][15]}}, pm_frame[(i*ch+c)%36]};
        accumulate_dct18(x);
      end
    end
    pm_blocks = pm_blocks + ch;
    if (pm_blocks > NBLK) pm_blocks = NBLK;
  endfunction

  // advance the predictor by one accepted sample; queue averages on last
  function automatic void predict_sample(bit [15:0] s, bit last, bit typed_empty);
    coef_res_t r;
    int flen;
    flen = pm_stereo ? 36 : 18;
    if (pm_count < 36) pm_frame[pm_count] = s;
    pm_count++;
    if (pm_count >= flen) begin
      close_frame();
      pm_count = 0;
    end
    if (!last) return;
    for (int k = 0; k < 18; k++) begin
      r.idx   = 5'(k);
      r.fin   = (k == 17);
      if (typed_empty) begin
        r.avg   = 32'd0;
        r.empty = 1'b1;
      end else begin
        r.avg   = (pm_blocks == 0) ? 32'd0 : 32'(int'(pm_sum[k]) / pm_blocks);
        r.empty = (pm_blocks == 0);
      end
      coef_q.push_back(r);
    end
    pm_count  = 0;
    pm_blocks = 0;
    foreach (pm_sum[i]) pm_sum[i] = '0;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    coef_res_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (coef_q.size() == 0) begin
        report_mismatch("unexpected result, index", out_tdata[4:0], -1);
      end else begin
        w = coef_q.pop_front();
        if (out_tdata[4:0] != w.idx) report_mismatch("coef_index", out_tdata[4:0], w.idx);
        if (out_tdata[36:5] != w.avg)
          report_mismatch("average", $signed(out_tdata[36:5]), $signed(w.avg));
        if (out_tuser != w.empty) report_mismatch("empty_res", out_tuser, w.empty);
        if (out_tlast != w.fin) report_mismatch("final_res", out_tlast, w.fin);
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  task automatic send_sample(bit [15:0] s, bit last, bit typed_empty);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_sample(s, last, typed_empty);
  endtask

  // hold the input until all averages are out and any transform has drained
  task automatic drain_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (coef_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_stereo(bit v);
    drain_block();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    pm_stereo = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic bit [15:0] rand_sample();
    bit [15:0] r;
    r = 16'($urandom);
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return {{8{r[7]}}, r[7:0]};
      3: return 16'($signed(r[5:0]));
      default: return r;
    endcase
  endfunction

  task automatic send_run(int len);
    for (int i = 1; i <= len; i++) send_sample(rand_sample(), i == len, 1'b0);
  endtask

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    int flen;
    int len;
    int sent;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    pm_stereo = 1'b0;
    pm_count  = 0;
    pm_blocks = 0;
    foreach (pm_sum[i]) pm_sum[i] = '0;
    foreach (pm_frame[i]) pm_frame[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_stereo(1'b0);
    // empty run right after reset
    rows.push_back('{16'h0000, 1'b1, 1'b1});
    // one full frame at the positive extreme
    for (int i = 0; i < 18; i++) rows.push_back('{16'h7fff, i == 17, 1'b0});
    // partial frame at the negative extreme is dropped: empty run
    for (int i = 0; i < 5; i++) rows.push_back('{16'h8000, i == 4, i == 4});
    foreach (rows[i]) begin
      row = rows[i];
      send_sample(row.sample, row.last, row.typed_empty);
    end

    for (int p = 0; p < 6; p++) begin
      tx_idle = (p < 2) ? 21 : (p < 4) ? 48 : 0;
      rx_idle = (p < 2) ? 48 : (p < 4) ? 21 : 0;
      write_stereo(p[0]);
      flen = p[0] ? 36 : 18;
      sent = 0;
      while (sent < 45) begin
        case ($urandom_range(0, 6))
          0: len = $urandom_range(1, 17);
          1, 2: len = flen * $urandom_range(1, 3);
          default: len = $urandom_range(18, 80);
        endcase
        send_run(len);
        sent += len;
      end
      // may leave a partial frame so the next mode can start mid-frame
      for (int i = $urandom_range(0, 30); i > 0; i--)
        send_sample(rand_sample(), 1'b0, 1'b0);
    end
    send_run(40);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (coef_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

FILE: files.f
design/ads_pkg.sv
design/ads_div.sv
design/ads_engine.sv
design/averaged_dct18_spectrum.sv
sim/testbench.sv
